// File: hw/rtl/ptp_sod_pkg.sv
`timescale 1ns / 1ps

package ptp_sod_pkg;

  localparam int SEQ_W  = 16;
  localparam int TIME_W = 63;
  localparam int DIFF_W = 64;

  localparam logic [SEQ_W-1:0] INTERVAL_RESET = 16'd100;

  localparam logic KIND_REQUEST = 1'b0;
  localparam logic KIND_MEASURE = 1'b1;

  typedef enum logic [2:0] {
    ACT_TICK       = 3'd0,
    ACT_SYNC       = 3'd1,
    ACT_FOLLOW_UP  = 3'd2,
    ACT_DELAY_RESP = 3'd3,
    ACT_OTHER      = 3'd4
  } action_e;

  typedef struct packed {
    logic              has_req;
    logic              has_meas;
    logic [SEQ_W-1:0]  req_seq;
    logic [TIME_W-1:0] req_time;
    logic [DIFF_W-1:0] ms;
    logic [DIFF_W-1:0] sm;
  } stamp_xfer_t;

  typedef struct packed {
    logic              has_req;
    logic              has_meas;
    logic [SEQ_W-1:0]  req_seq;
    logic [TIME_W-1:0] req_time;
    logic [DIFF_W-1:0] diff;
    logic [DIFF_W-1:0] sum;
  } meas_xfer_t;

endpackage

// File: hw/rtl/ptp_sod_collect.sv
`timescale 1ns / 1ps

module ptp_sod_collect import ptp_sod_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_wr_en_i,
  input  logic [SEQ_W-1:0]  cfg_wr_data_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [2:0]        action_i,
  input  logic [SEQ_W-1:0]  sequence_id_i,
  input  logic              two_step_i,
  input  logic [TIME_W-1:0] message_time_ns_i,
  input  logic [TIME_W-1:0] local_time_ns_i,
  input  logic              advance_i,
  output logic              xfer_valid_o,
  output stamp_xfer_t       xfer_o
);

  logic [SEQ_W-1:0]  interval_q;
  logic [SEQ_W-1:0]  sync_seq_q, sync_seq_d;
  logic [SEQ_W-1:0]  req_seq_q, req_seq_d;
  logic [SEQ_W-1:0]  tick_cnt_q, tick_cnt_d;
  logic [SEQ_W-1:0]  tick_inc;
  logic [3:0]        stamp_vld_q, stamp_vld_d, stamp_vld_upd;
  logic [TIME_W-1:0] t1_q, t1_d, t2_q, t2_d, t3_q, t3_d, t4_q, t4_d;
  logic              fire, complete, in_accept;
  logic              xfer_valid_q;
  stamp_xfer_t       xfer_q, xfer_d;

  assign in_stall_o = xfer_valid_q && !advance_i;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign tick_inc   = tick_cnt_q + 1'b1;

  always_comb begin
    sync_seq_d    = sync_seq_q;
    req_seq_d     = req_seq_q;
    tick_cnt_d    = tick_cnt_q;
    stamp_vld_upd = stamp_vld_q;
    t1_d          = t1_q;
    t2_d          = t2_q;
    t3_d          = t3_q;
    t4_d          = t4_q;
    fire          = 1'b0;
    unique case (action_e'(action_i))
      ACT_TICK: begin
        fire = (tick_inc >= interval_q);
        if (fire) begin
          tick_cnt_d       = '0;
          req_seq_d        = req_seq_q + 1'b1;
          t3_d             = local_time_ns_i;
          stamp_vld_upd[2] = 1'b1;
        end else begin
          tick_cnt_d = tick_inc;
        end
      end
      ACT_SYNC: begin
        t2_d             = local_time_ns_i;
        stamp_vld_upd[1] = 1'b1;
        sync_seq_d       = sequence_id_i;
        if (!two_step_i) begin
          t1_d             = message_time_ns_i;
          stamp_vld_upd[0] = 1'b1;
        end
      end
      ACT_FOLLOW_UP: begin
        if (sequence_id_i == sync_seq_q) begin
          t1_d             = message_time_ns_i;
          stamp_vld_upd[0] = 1'b1;
        end
      end
      ACT_DELAY_RESP: begin
        if (sequence_id_i == req_seq_q) begin
          t4_d             = message_time_ns_i;
          stamp_vld_upd[3] = 1'b1;
        end
      end
      ACT_OTHER: ;
      default: ;
    endcase
    complete    = &stamp_vld_upd;
    stamp_vld_d = complete ? 4'b0000 : stamp_vld_upd;

    xfer_d.has_req  = fire;
    xfer_d.has_meas = complete;
    xfer_d.req_seq  = req_seq_d;
    xfer_d.req_time = local_time_ns_i;
    xfer_d.ms       = {1'b0, t2_d} - {1'b0, t1_d};
    xfer_d.sm       = {1'b0, t4_d} - {1'b0, t3_d};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q   <= INTERVAL_RESET;
      sync_seq_q   <= '0;
      req_seq_q    <= '0;
      tick_cnt_q   <= '0;
      stamp_vld_q  <= '0;
      xfer_valid_q <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        interval_q <= cfg_wr_data_i;
      end
      if (in_accept) begin
        sync_seq_q   <= sync_seq_d;
        req_seq_q    <= req_seq_d;
        tick_cnt_q   <= tick_cnt_d;
        stamp_vld_q  <= stamp_vld_d;
        xfer_valid_q <= fire || complete;
      end else if (advance_i) begin
        xfer_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      t1_q   <= t1_d;
      t2_q   <= t2_d;
      t3_q   <= t3_d;
      t4_q   <= t4_d;
      xfer_q <= xfer_d;
    end
  end

  assign xfer_valid_o = xfer_valid_q;
  assign xfer_o       = xfer_q;

endmodule

// File: hw/rtl/ptp_sod_arith.sv
`timescale 1ns / 1ps

module ptp_sod_arith import ptp_sod_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        xfer_valid_i,
  input  stamp_xfer_t xfer_i,
  output logic        advance_o,
  input  logic        consume_i,
  output logic        meas_valid_o,
  output meas_xfer_t  meas_o
);

  logic       valid_q;
  meas_xfer_t meas_q, meas_d;

  assign advance_o = !valid_q || consume_i;

  always_comb begin
    meas_d.has_req  = xfer_i.has_req;
    meas_d.has_meas = xfer_i.has_meas;
    meas_d.req_seq  = xfer_i.req_seq;
    meas_d.req_time = xfer_i.req_time;
    meas_d.diff     = xfer_i.ms - xfer_i.sm;
    meas_d.sum      = xfer_i.ms + xfer_i.sm;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (advance_o) begin
      valid_q <= xfer_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance_o && xfer_valid_i) begin
      meas_q <= meas_d;
    end
  end

  assign meas_valid_o = valid_q;
  assign meas_o       = meas_q;

endmodule

// File: hw/rtl/ptp_sod_emit.sv
`timescale 1ns / 1ps

module ptp_sod_emit import ptp_sod_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     meas_valid_i,
  input  meas_xfer_t               meas_i,
  output logic                     consume_o,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     kind_o,
  output logic signed [DIFF_W-1:0] offset_ns_o,
  output logic signed [DIFF_W-1:0] path_delay_ns_o,
  output logic [SEQ_W-1:0]         request_sequence_o,
  output logic [TIME_W-1:0]        request_time_ns_o,
  output logic                     last_o
);

  logic              out_valid_q;
  logic              req_done_q;
  logic              load, emit_req;
  logic [DIFF_W-1:0] diff_rnd, sum_rnd, off_half, dly_half;
  logic              kind_q;
  logic [DIFF_W-1:0] offset_q, delay_q;
  logic [SEQ_W-1:0]  req_seq_q;
  logic [TIME_W-1:0] req_time_q;
  logic              last_q;

  assign load      = meas_valid_i && (!out_valid_q || !out_stall_i);
  assign emit_req  = meas_i.has_req && !req_done_q;
  assign consume_o = load && !(emit_req && meas_i.has_meas);

  // halve toward zero: bias negative values by one before the arithmetic shift
  assign diff_rnd = meas_i.diff + DIFF_W'(meas_i.diff[DIFF_W-1]);
  assign sum_rnd  = meas_i.sum + DIFF_W'(meas_i.sum[DIFF_W-1]);
  assign off_half = {diff_rnd[DIFF_W-1], diff_rnd[DIFF_W-1:1]};
  assign dly_half = {sum_rnd[DIFF_W-1], sum_rnd[DIFF_W-1:1]};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      req_done_q  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        req_done_q  <= emit_req && meas_i.has_meas;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      if (emit_req) begin
        kind_q     <= KIND_REQUEST;
        offset_q   <= '0;
        delay_q    <= '0;
        req_seq_q  <= meas_i.req_seq;
        req_time_q <= meas_i.req_time;
        last_q     <= !meas_i.has_meas;
      end else begin
        kind_q     <= KIND_MEASURE;
        offset_q   <= off_half;
        delay_q    <= dly_half;
        req_seq_q  <= '0;
        req_time_q <= '0;
        last_q     <= 1'b1;
      end
    end
  end

  assign out_valid_o        = out_valid_q;
  assign kind_o             = kind_q;
  assign offset_ns_o        = offset_q;
  assign path_delay_ns_o    = delay_q;
  assign request_sequence_o = req_seq_q;
  assign request_time_ns_o  = req_time_q;
  assign last_o             = last_q;

endmodule

// File: hw/rtl/ptp_slave_offset_delay.sv
`timescale 1ns / 1ps
// Path: each result is registered in the collect, arith and emit stages in turn.
// Throughput: one transaction per cycle while in_stall_o is low; a tick that
// also completes a measurement yields two results from the single output register.
// Transactions that produce no result are dropped after the first stage.
// Reset: clears counters, sequence numbers and stamp flags; interval reloads to 100.

module ptp_slave_offset_delay import ptp_sod_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_wr_en_i,
  input  logic [SEQ_W-1:0]         cfg_wr_data_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [2:0]               action_i,
  input  logic [SEQ_W-1:0]         sequence_id_i,
  input  logic                     two_step_i,
  input  logic [TIME_W-1:0]        message_time_ns_i,
  input  logic [TIME_W-1:0]        local_time_ns_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     kind_o,
  output logic signed [DIFF_W-1:0] offset_ns_o,
  output logic signed [DIFF_W-1:0] path_delay_ns_o,
  output logic [SEQ_W-1:0]         request_sequence_o,
  output logic [TIME_W-1:0]        request_time_ns_o,
  output logic                     last_o
);

  logic        xfer_valid, advance, meas_valid, consume;
  stamp_xfer_t xfer;
  meas_xfer_t  meas;

  ptp_sod_collect u_collect (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_wr_en_i       (cfg_wr_en_i),
    .cfg_wr_data_i     (cfg_wr_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .action_i          (action_i),
    .sequence_id_i     (sequence_id_i),
    .two_step_i        (two_step_i),
    .message_time_ns_i (message_time_ns_i),
    .local_time_ns_i   (local_time_ns_i),
    .advance_i         (advance),
    .xfer_valid_o      (xfer_valid),
    .xfer_o            (xfer)
  );

  ptp_sod_arith u_arith (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .xfer_valid_i (xfer_valid),
    .xfer_i       (xfer),
    .advance_o    (advance),
    .consume_i    (consume),
    .meas_valid_o (meas_valid),
    .meas_o       (meas)
  );

  ptp_sod_emit u_emit (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .meas_valid_i       (meas_valid),
    .meas_i             (meas),
    .consume_o          (consume),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .kind_o             (kind_o),
    .offset_ns_o        (offset_ns_o),
    .path_delay_ns_o    (path_delay_ns_o),
    .request_sequence_o (request_sequence_o),
    .request_time_ns_o  (request_time_ns_o),
    .last_o             (last_o)
  );

endmodule
